// ----- rtl/framed_command_uart_transmitter_core_assert.svh -----
// Assertion macros for the framed command UART transmitter.
// Included by the modules that check their own logic; no other dependencies.
`ifndef FRAMED_COMMAND_UART_TRANSMITTER_CORE_ASSERT_SVH
`define FRAMED_COMMAND_UART_TRANSMITTER_CORE_ASSERT_SVH

`ifndef SYNTH
`define FCUT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("fcut assertion failed");
`define FCUT_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("fcut forbidden condition");
`else
`define FCUT_ASSERT(label, clk, rst, prop)
`define FCUT_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

// ----- rtl/fcut_pkg.sv -----
// Shared types and constants of the framed command UART transmitter.
// No dependencies; imported by every module of the block.
package fcut_pkg;

  localparam int DATA_BITS   = 8;
  localparam int BIT_SLOTS   = DATA_BITS + 2;
  localparam int SLOT_W      = $clog2(BIT_SLOTS);
  localparam int DBIT_W      = $clog2(DATA_BITS);
  localparam int HDR_BYTES   = 5;
  localparam int NBYTES_W    = $clog2(HDR_BYTES + 1);
  localparam int JOB_W       = HDR_BYTES * DATA_BITS;
  localparam int PERIOD_W    = 16;
  localparam int LEN_W       = 8;

  localparam logic [DATA_BITS-1:0] HDR_SYNC  = 8'hFD;
  localparam logic [DATA_BITS-1:0] HDR_CMD   = 8'h01;
  localparam logic [DATA_BITS-1:0] HDR_PARAM = 8'h01;
  localparam logic [PERIOD_W-1:0]  PERIOD_RESET = 16'd413;

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_PAYLOAD = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [NBYTES_W-1:0] nbytes;
    logic [JOB_W-1:0]    bytes;
  } fcut_job_t;

endpackage

// ----- rtl/fcut_frame_dec.sv -----
// Input register, frame decoder and payload counter of the UART transmitter.
// Depends on fcut_pkg and the assertion macro header.
`include "framed_command_uart_transmitter_core_assert.svh"

module fcut_frame_dec
  import fcut_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [PERIOD_W-1:0]  bit_period,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  cmd_t                 s_cmd,
  input  logic [LEN_W-1:0]     s_len,
  input  logic [DATA_BITS-1:0] s_data,
  output logic                 job_valid,
  input  logic                 job_ready,
  output fcut_job_t            job
);

  logic                 a_valid;
  cmd_t                 a_cmd;
  logic [LEN_W-1:0]     a_len;
  logic [DATA_BITS-1:0] a_data;
  logic [LEN_W-1:0]     payload_remaining;
  logic [LEN_W-1:0]     payload_remaining_next;
  logic                 a_take;
  logic                 enabled;
  logic [LEN_W:0]       framed;

  assign enabled  = (bit_period != '0);
  assign framed   = {1'b0, a_len} + (LEN_W + 1)'(2);
  assign s_tready = !a_valid || a_take;
  assign a_take   = a_valid && ((job.nbytes == '0) || job_ready);
  assign job_valid = a_valid && (job.nbytes != '0);

  always_comb begin
    job.nbytes             = '0;
    job.bytes              = '0;
    payload_remaining_next = payload_remaining;
    unique case (a_cmd)
      CMD_START: begin
        payload_remaining_next = a_len;
        job.bytes = {HDR_PARAM, HDR_CMD, framed[DATA_BITS-1:0],
                     DATA_BITS'(framed[LEN_W:DATA_BITS]), HDR_SYNC};
        if (enabled) begin
          job.nbytes = NBYTES_W'(HDR_BYTES);
        end
      end
      CMD_PAYLOAD: begin
        job.bytes = JOB_W'(a_data);
        if (payload_remaining != '0) begin
          payload_remaining_next = payload_remaining - LEN_W'(1);
          if (enabled) begin
            job.nbytes = NBYTES_W'(1);
          end
        end
      end
      default: begin
        job.nbytes = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid           <= 1'b0;
      payload_remaining <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        a_valid <= 1'b1;
      end else if (a_take) begin
        a_valid <= 1'b0;
      end
      if (a_take) begin
        payload_remaining <= payload_remaining_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_cmd  <= s_cmd;
      a_len  <= s_len;
      a_data <= s_data;
    end
  end

  `FCUT_ASSERT(a_rem_changes_on_take, clk, rst,
    (payload_remaining != $past(payload_remaining)) |-> $past(a_take))
  `FCUT_ASSERT(a_drop_when_exhausted, clk, rst,
    (a_valid && a_cmd == CMD_PAYLOAD && payload_remaining == '0) |-> !job_valid)
  `FCUT_ASSERT(a_silent_when_disabled, clk, rst,
    (bit_period == '0) |-> !job_valid)

endmodule

// ----- rtl/fcut_bit_ser.sv -----
// Bit serializer and output register: sends each job byte as start, data, stop.
// Depends on fcut_pkg and the assertion macro header.
`include "framed_command_uart_transmitter_core_assert.svh"

module fcut_bit_ser
  import fcut_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  output logic      job_ready,
  input  fcut_job_t job,
  output logic      m_tvalid,
  input  logic      m_tready,
  output logic      m_level,
  output logic      m_tlast
);

  logic                 busy;
  logic [JOB_W-1:0]     bytes;
  logic [NBYTES_W-1:0]  bytes_left;
  logic [SLOT_W-1:0]    bit_idx;
  logic                 out_load;
  logic                 slot_end;
  logic                 job_end;
  logic [SLOT_W-1:0]    dbit;
  logic                 level_next;

  assign out_load  = busy && (!m_tvalid || m_tready);
  assign slot_end  = (bit_idx == SLOT_W'(BIT_SLOTS - 1));
  assign job_end   = slot_end && (bytes_left == NBYTES_W'(1));
  assign job_ready = !busy || (out_load && job_end);
  assign dbit      = bit_idx - SLOT_W'(1);

  always_comb begin
    if (bit_idx == '0) begin
      level_next = 1'b0;
    end else if (slot_end) begin
      level_next = 1'b1;
    end else begin
      level_next = bytes[dbit[DBIT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
      bit_idx  <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (job_ready && job_valid) begin
        busy    <= 1'b1;
        bit_idx <= '0;
      end else if (out_load) begin
        if (job_end) begin
          busy <= 1'b0;
        end
        bit_idx <= slot_end ? '0 : bit_idx + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      bytes      <= job.bytes;
      bytes_left <= job.nbytes;
    end else if (out_load && slot_end) begin
      bytes      <= bytes >> DATA_BITS;
      bytes_left <= bytes_left - NBYTES_W'(1);
    end
    if (out_load) begin
      m_level <= level_next;
      m_tlast <= job_end;
    end
  end

  `FCUT_ASSERT_NEVER(a_slot_in_range, clk, rst,
    busy && (bit_idx > SLOT_W'(BIT_SLOTS - 1)))
  `FCUT_ASSERT(a_busy_has_bytes, clk, rst, busy |-> (bytes_left != '0))
  `FCUT_ASSERT(a_last_is_stop, clk, rst, (m_tvalid && m_tlast) |-> m_level)
  `FCUT_ASSERT(a_busy_from_job, clk, rst, $rose(busy) |-> $past(job_valid))

endmodule

// ----- rtl/framed_command_uart_transmitter_core.sv -----
// Framed command UART transmitter core: a start transaction (tuser = 0) sends
// the five header bytes FD, (len+2) high, (len+2) low, 01, 01 and loads the
// payload count; each payload transaction (tuser = 1) sends one text byte while
// the count lasts and is dropped after it. Every byte leaves as 10 line-bit
// transactions (start 0, eight data bits LSB first, stop 1), tlast on the
// final bit of the input transaction: 50 output transactions for a start,
// 10 for a payload byte, none when bit_period is zero or the byte is dropped.
// The serializer emits one bit per cycle while m_tready is high; a one-entry
// input register takes the next transaction while bits are still going out.
// The sink holds each bit on the pin for bit_period time units.
// Depends on fcut_pkg, fcut_frame_dec and fcut_bit_ser.
module framed_command_uart_transmitter_core
  import fcut_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // bit_period
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,       // [7:0] text_length, [15:8] data_byte
  input  logic [0:0]  s_tuser,       // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,       // [0] line_level, [7:1] zero
  output logic        m_tlast
);

  logic [PERIOD_W-1:0] bit_period;
  logic                job_valid;
  logic                job_ready;
  fcut_job_t           job;
  logic                m_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period <= PERIOD_RESET;
    end else if (cfg_wr_en) begin
      bit_period <= cfg_wr_data;
    end
  end

  fcut_frame_dec u_dec (
    .clk       (clk),
    .rst       (rst),
    .bit_period(bit_period),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_cmd     (cmd_t'(s_tuser[0])),
    .s_len     (s_tdata[7:0]),
    .s_data    (s_tdata[15:8]),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  fcut_bit_ser u_ser (
    .clk      (clk),
    .rst      (rst),
    .job_valid(job_valid),
    .job_ready(job_ready),
    .job      (job),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_level  (m_level),
    .m_tlast  (m_tlast)
  );

  assign m_tdata = {7'd0, m_level};

endmodule

// ----- dv/framed_command_uart_transmitter_core_tb.sv -----
// Testbench for framed_command_uart_transmitter_core: start and payload
// transactions in, predicted 8N1 line bits checked against the serial output.
// Depends on fcut_pkg and the block itself; needs no other files.
module framed_command_uart_transmitter_core_tb;
  import fcut_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 3000;
  localparam int PHASE_ITEMS  = 52;

  typedef struct packed {
    logic level;
    logic is_last;
  } line_bit_t;

  class serial_frame_tracker;
    logic [PERIOD_W-1:0] bit_period;
    logic [LEN_W-1:0]    payload_left;
    line_bit_t           line_bits_due[$];
    int                  errors;
    int                  bits_checked;

    function new();
      bit_period   = PERIOD_RESET;
      payload_left = '0;
      errors       = 0;
      bits_checked = 0;
    endfunction

    function void set_period(logic [PERIOD_W-1:0] period);
      bit_period = period;
    endfunction

    function int pending();
      return line_bits_due.size();
    endfunction

    function void push_byte(logic [DATA_BITS-1:0] value);
      line_bits_due.push_back('{level: 1'b0, is_last: 1'b0});
      for (int k = 0; k < DATA_BITS; k++) begin
        line_bits_due.push_back('{level: value[k], is_last: 1'b0});
      end
      line_bits_due.push_back('{level: 1'b1, is_last: 1'b0});
    endfunction

    function void note_transaction(cmd_t cmd, logic [LEN_W-1:0] text_length,
                                   logic [DATA_BITS-1:0] data_byte);
      logic [LEN_W:0] framed;
      if (cmd == CMD_START) begin
        payload_left = text_length;
        if (bit_period == '0) return;
        framed = {1'b0, text_length} + 9'd2;
        push_byte(HDR_SYNC);
        push_byte({7'd0, framed[LEN_W]});
        push_byte(framed[LEN_W-1:0]);
        push_byte(HDR_CMD);
        push_byte(HDR_PARAM);
      end else begin
        if (payload_left == '0) return;
        payload_left = payload_left - LEN_W'(1);
        if (bit_period == '0) return;
        push_byte(data_byte);
      end
      line_bits_due[line_bits_due.size() - 1].is_last = 1'b1;
    endfunction

    function void check_line_bit(logic level, logic is_last, logic [6:0] pad);
      line_bit_t want;
      if (line_bits_due.size() == 0) begin
        $display("%0t: unexpected line bit: expected none, actual level=%0b last=%0b",
                 $time, level, is_last);
        errors++;
        return;
      end
      want = line_bits_due.pop_front();
      bits_checked++;
      if (level !== want.level) begin
        $display("%0t: line_level expected %0b actual %0b", $time, want.level, level);
        errors++;
      end
      if (is_last !== want.is_last) begin
        $display("%0t: tlast expected %0b actual %0b", $time, want.is_last, is_last);
        errors++;
      end
      if (pad !== 7'd0) begin
        $display("%0t: tdata[7:1] expected 0 actual %0h", $time, pad);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;       // [7:0] text_length, [15:8] data_byte
  logic [0:0]  s_tuser = '0;       // [0] cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;            // [0] line_level, [7:1] zero
  logic        m_tlast;

  serial_frame_tracker tracker;
  int  burst_left = 0;
  int  sent_items = 0;
  int  hold_after_items = -1;
  bit  hold_req = 1'b0;
  int  quiet_cycles = 0;

  always #1 clk = ~clk;

  framed_command_uart_transmitter_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) tracker.check_line_bit(m_tdata[0], m_tlast, m_tdata[7:1]);
      if (s_tvalid && s_tready) begin
        tracker.note_transaction(cmd_t'(s_tuser[0]), s_tdata[7:0], s_tdata[15:8]);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int mode;
    int span;
    logic ready;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      repeat (span) begin
        if (hold_req) break;
        case (mode)
          0: begin
            ready = 1'b1;
          end
          1: begin
            ready = 1'($urandom_range(0, 1));
          end
          2: begin
            ready = ($urandom_range(0, 3) == 0);
          end
          default: begin
            ready = ($urandom_range(0, 7) != 0);
          end
        endcase
        m_tready <= ready;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(input cmd_t cmd, input logic [7:0] text_length,
                           input logic [7:0] data_byte);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    if (sent_items == hold_after_items) hold_req = 1'b1;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {data_byte, text_length};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_start(input logic [7:0] text_length);
    send_item(CMD_START, text_length, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_payload(input logic [7:0] data_byte);
    send_item(CMD_PAYLOAD, 8'($urandom_range(0, 255)), data_byte);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [15:0] period);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= period;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_period(period);
  endtask

  task automatic run_random(input int budget);
    int done_items;
    int choice;
    int text_length;
    int count;
    done_items = 0;
    while (done_items < budget) begin
      choice = $urandom_range(0, 9);
      if (choice == 0) begin
        send_payload(8'($urandom_range(0, 255)));
        done_items++;
      end else begin
        text_length = ($urandom_range(0, 11) == 0) ? $urandom_range(240, 255)
                                                   : $urandom_range(0, 8);
        send_start(8'(text_length));
        done_items++;
        count = text_length;
        if (choice == 1) count = $urandom_range(0, text_length);
        else if (choice == 2) count = text_length + $urandom_range(1, 2);
        if (count > budget - done_items) count = budget - done_items;
        repeat (count) begin
          send_payload(8'($urandom_range(0, 255)));
          done_items++;
        end
      end
    end
  endtask

  initial begin
    tracker = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_start(8'd0);
    send_payload(8'h3C);
    send_start(8'd3);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_payload(8'hA5);
    send_payload(8'h3C);
    send_start(8'd254);
    send_payload(8'h5A);
    send_start(8'd255);
    send_payload(8'h81);
    send_start(8'd253);
    send_payload(8'h7E);
    send_start(8'd1);
    send_payload(8'hFF);
    send_payload(8'h00);
    settle();

    write_period(16'd0);
    send_start(8'd2);
    send_payload(8'h11);
    send_payload(8'h22);
    send_payload(8'h33);
    send_start(8'd255);
    send_payload(8'h44);
    settle();

    hold_after_items = sent_items + PHASE_ITEMS + 15;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_period(16'hFFFF);
        end
        1: begin
          write_period(16'd1);
        end
        2: begin
          write_period(16'd0);
        end
        default: begin
          write_period(16'($urandom_range(2, 65534)));
        end
      endcase
      run_random(PHASE_ITEMS);
      settle();
    end

    $display("sent %0d start and payload transactions, checked %0d line bits", sent_items,
             tracker.bits_checked);
    $display("bit periods covered: reset, 0, 1, 65535 and random; one long output stall");
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
